FILE: hw/rtl/jsp_pkg.sv
package jsp_pkg;

  localparam int unsigned ValW  = 48;
  localparam int unsigned CfgW  = 47;
  localparam int unsigned IdxW  = 7;
  localparam int unsigned SumW  = 49;
  localparam int unsigned PrdW  = 54;
  localparam int unsigned ExW   = 56;
  localparam int unsigned TotW  = 64;
  localparam int unsigned MagW  = 64;
  localparam int unsigned AccW  = 112;
  localparam int unsigned RndW  = 80;
  localparam int unsigned TrmW  = 63;

  localparam logic [CfgW-1:0] Mask47   = {CfgW{1'b1}};
  localparam logic [RndW-1:0] TermLim  = RndW'(1) << 61;
  localparam logic [RndW-1:0] PosLim   = (RndW'(1) << 47) - RndW'(1);
  localparam logic [RndW-1:0] NegLim   = RndW'(1) << 47;
  localparam logic [ValW-1:0] NewMax   = {1'b0, {(ValW-1){1'b1}}};
  localparam logic [ValW-1:0] NewMin   = {1'b1, {(ValW-1){1'b0}}};

  typedef enum logic [2:0] {
    CfgInvHx  = 3'd0,
    CfgInvHy  = 3'd1,
    CfgInvHz  = 3'd2,
    CfgInvDg  = 3'd3,
    CfgStepX  = 3'd4,
    CfgStepY  = 3'd5,
    CfgStepZ  = 3'd6,
    CfgEps    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [ValW-1:0] north_z;
    logic signed [ValW-1:0] south_z;
    logic signed [ValW-1:0] north_y;
    logic signed [ValW-1:0] south_y;
    logic signed [ValW-1:0] north_x;
    logic signed [ValW-1:0] south_x;
    logic signed [ValW-1:0] center_old;
    logic [IdxW-1:0]        x_index;
    logic [IdxW-1:0]        y_index;
    logic [IdxW-1:0]        z_index;
    logic                   sweep_start;
  } in_t;

  typedef struct packed {
    logic signed [ValW-1:0] new_value;
    logic                   point_moved;
    logic                   any_moved;
    logic [CfgW-1:0]        max_error;
  } out_t;

  typedef struct packed {
    logic [CfgW-1:0] inv_hx_sq;
    logic [CfgW-1:0] inv_hy_sq;
    logic [CfgW-1:0] inv_hz_sq;
    logic [CfgW-1:0] inv_diag;
    logic [CfgW-1:0] step_x;
    logic [CfgW-1:0] step_y;
    logic [CfgW-1:0] step_z;
    logic [CfgW-1:0] epsilon;
  } cfg_t;

  typedef struct packed {
    logic signed [SumW-1:0] sx;
    logic signed [SumW-1:0] sy;
    logic signed [SumW-1:0] sz;
    logic signed [ValW-1:0] old;
    logic [ExW-1:0]         exact;
    logic                   sweep;
  } q_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

  // (p + 2^31) >> 32
  function automatic logic [RndW-1:0] rnd_shift(input logic [AccW-1:0] p);
    logic [AccW:0] s;
    s = {1'b0, p} + (AccW+1)'(64'h8000_0000);
    return s[AccW-1:32];
  endfunction

endpackage

FILE: hw/rtl/jsp_mul.sv
module jsp_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [jsp_pkg::MagW-1:0]   a_i,
  input  logic [jsp_pkg::CfgW-1:0]   b_i,
  output logic                       done_o,
  output logic [jsp_pkg::AccW-1:0]   prod_o
);
  import jsp_pkg::*;

  logic [MagW-1:0] a_q;
  logic [CfgW-1:0] b_q;
  logic [AccW-1:0] acc_q;
  logic [1:0]      cnt_q;
  logic            run_q;
  logic            done_q;
  logic [62:0]     pp;

  // 16-bit digit of a per cycle, LSB first, accumulator shifts right
  assign pp = 63'(a_q[15:0]) * 63'(b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == 2'd3);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (run_q) begin
      a_q   <= a_q >> 16;
      acc_q <= (acc_q >> 16) + {1'b0, pp, 48'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

FILE: hw/rtl/jsp_front.sv
module jsp_front #(
  parameter int GRID_N = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  jsp_pkg::in_t       in_data_i,
  input  jsp_pkg::cfg_t      cfg_i,
  input  jsp_pkg::fifo_st_t  fifo_st_i,
  output logic               push_o,
  output jsp_pkg::q_t        push_data_o
);
  import jsp_pkg::*;

  localparam int IdxLim = (GRID_N + 1 > 127) ? 127 : GRID_N + 1;

  logic                   f_valid_q, f_valid_d;
  logic                   accept;
  logic signed [SumW-1:0] sx_q, sy_q, sz_q;
  logic signed [ValW-1:0] old_q;
  logic [PrdW-1:0]        px_q, py_q, pz_q;
  logic                   sweep_q;
  logic [IdxW-1:0]        xi, yi, zi;

  function automatic logic [IdxW-1:0] clamp(input logic [IdxW-1:0] i);
    logic [IdxW-1:0] r;
    r = i;
    if (int'(i) > IdxLim) r = IdxW'(IdxLim);
    return r;
  endfunction

  assign xi = clamp(in_data_i.x_index);
  assign yi = clamp(in_data_i.y_index);
  assign zi = clamp(in_data_i.z_index);

  assign push_o     = f_valid_q && !fifo_st_i.full;
  assign in_stall_o = f_valid_q && fifo_st_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    f_valid_d = f_valid_q;
    if (accept) f_valid_d = 1'b1;
    else if (push_o) f_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sx_q    <= SumW'(in_data_i.north_x) + SumW'(in_data_i.south_x);
      sy_q    <= SumW'(in_data_i.north_y) + SumW'(in_data_i.south_y);
      sz_q    <= SumW'(in_data_i.north_z) + SumW'(in_data_i.south_z);
      old_q   <= in_data_i.center_old;
      px_q    <= PrdW'(xi) * PrdW'(cfg_i.step_x);
      py_q    <= PrdW'(yi) * PrdW'(cfg_i.step_y);
      pz_q    <= PrdW'(zi) * PrdW'(cfg_i.step_z);
      sweep_q <= in_data_i.sweep_start;
    end
  end

  always_comb begin
    push_data_o.sx    = sx_q;
    push_data_o.sy    = sy_q;
    push_data_o.sz    = sz_q;
    push_data_o.old   = old_q;
    push_data_o.exact = ExW'(px_q) + ExW'(py_q) + ExW'(pz_q);
    push_data_o.sweep = sweep_q;
  end

endmodule

FILE: hw/rtl/jsp_fifo.sv
module jsp_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  jsp_pkg::q_t        push_data_i,
  input  logic               pop_i,
  output jsp_pkg::q_t        head_o,
  output jsp_pkg::fifo_st_t  st_o
);
  import jsp_pkg::*;

  q_t         mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  assign head_o   = mem_q[rd_q];
  assign st_o.full  = (cnt_q == 2'd2);
  assign st_o.empty = (cnt_q == 2'd0);

endmodule

FILE: hw/rtl/jsp_back.sv
module jsp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jsp_pkg::cfg_t      cfg_i,
  input  jsp_pkg::fifo_st_t  fifo_st_i,
  input  jsp_pkg::q_t        head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output jsp_pkg::out_t      out_data_o
);
  import jsp_pkg::*;

  typedef enum logic [7:0] {
    StIdle = 8'b0000_0001,
    StMx   = 8'b0000_0010,
    StMy   = 8'b0000_0100,
    StMz   = 8'b0000_1000,
    StSum  = 8'b0001_0000,
    StDiag = 8'b0010_0000,
    StMd   = 8'b0100_0000,
    StFin  = 8'b1000_0000
  } st_e;

  st_e                    st_q, st_d;
  q_t                     ent_q;
  logic signed [TrmW-1:0] tx_q, ty_q, tz_q, term;
  logic signed [TotW-1:0] tot_q;
  logic signed [ValW-1:0] nv_q, nv_d;
  logic                   out_valid_q;
  out_t                   out_q;
  logic                   flag_q;
  logic [CfgW-1:0]        max_q;

  logic                   m_start, m_done;
  logic [MagW-1:0]        m_a;
  logic [CfgW-1:0]        m_b;
  logic [AccW-1:0]        m_prod;
  logic signed [SumW-1:0] op_s;
  logic                   op_neg, t_neg;
  logic [RndW-1:0]        rnd;
  logic [61:0]            tmag;
  logic                   fin_go;

  logic signed [SumW-1:0]   dchg;
  logic [SumW-1:0]          chg;
  logic                     moved;
  logic signed [ExW:0]      derr;
  logic [ExW:0]             emag;
  logic [CfgW-1:0]          err, max_base, max_d;
  logic                     flag_base;

  jsp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (m_start),
    .a_i     (m_a),
    .b_i     (m_b),
    .done_o  (m_done),
    .prod_o  (m_prod)
  );

  assign pop_o  = (st_q == StIdle) && !fifo_st_i.empty;
  assign fin_go = (st_q == StFin) && (!out_valid_q || !out_stall_i);

  always_comb begin
    op_s = head_i.sx;
    m_b  = cfg_i.inv_hx_sq;
    case (st_q)
      StMx: begin
        op_s = ent_q.sy;
        m_b  = cfg_i.inv_hy_sq;
      end
      StMy: begin
        op_s = ent_q.sz;
        m_b  = cfg_i.inv_hz_sq;
      end
      StDiag: m_b = cfg_i.inv_diag;
      default: ;
    endcase
    op_neg = op_s[SumW-1];
    m_a    = MagW'($unsigned(op_neg ? -op_s : op_s));
    if (st_q == StDiag) begin
      m_a = tot_q[TotW-1] ? MagW'(-tot_q) : MagW'(tot_q);
    end
    m_start = pop_o || st_q == StDiag ||
              (m_done && (st_q == StMx || st_q == StMy));
  end

  always_comb begin
    rnd = rnd_shift(m_prod);
    tmag = (rnd > TermLim) ? TermLim[61:0] : rnd[61:0];
    case (st_q)
      StMy:    t_neg = ent_q.sy[SumW-1];
      StMz:    t_neg = ent_q.sz[SumW-1];
      default: t_neg = ent_q.sx[SumW-1];
    endcase
    term = t_neg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
    if (tot_q[TotW-1]) begin
      nv_d = (rnd > NegLim) ? NewMin : -$signed(ValW'(rnd));
    end else begin
      nv_d = (rnd > PosLim) ? NewMax : $signed(ValW'(rnd));
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (pop_o) st_d = StMx;
      StMx:   if (m_done) st_d = StMy;
      StMy:   if (m_done) st_d = StMz;
      StMz:   if (m_done) st_d = StSum;
      StSum:  st_d = StDiag;
      StDiag: st_d = StMd;
      StMd:   if (m_done) st_d = StFin;
      StFin:  if (fin_go) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_comb begin
    dchg      = SumW'(nv_q) - SumW'(ent_q.old);
    chg       = dchg[SumW-1] ? SumW'(-dchg) : SumW'(dchg);
    moved     = chg > SumW'(cfg_i.epsilon);
    derr      = $signed((ExW+1)'(nv_q)) - $signed({1'b0, ent_q.exact});
    emag      = derr[ExW] ? (ExW+1)'(-derr) : (ExW+1)'(derr);
    err       = (emag > (ExW+1)'(Mask47)) ? Mask47 : emag[CfgW-1:0];
    flag_base = ent_q.sweep ? 1'b0 : flag_q;
    max_base  = ent_q.sweep ? '0 : max_q;
    max_d     = max_base;
    if (!moved && err > max_base) max_d = err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      out_valid_q <= 1'b0;
      flag_q      <= 1'b0;
      max_q       <= '0;
    end else begin
      st_q <= st_d;
      if (fin_go) begin
        out_valid_q <= 1'b1;
        flag_q      <= flag_base | moved;
        max_q       <= max_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) ent_q <= head_i;
    if (st_q == StMx && m_done) tx_q <= term;
    if (st_q == StMy && m_done) ty_q <= term;
    if (st_q == StMz && m_done) tz_q <= term;
    if (st_q == StSum) begin
      tot_q <= TotW'(tx_q) + TotW'(ty_q) + TotW'(tz_q) +
               $signed({{(TotW-ExW){1'b0}}, ent_q.exact});
    end
    if (st_q == StMd && m_done) nv_q <= nv_d;
    if (fin_go) begin
      out_q.new_value   <= nv_q;
      out_q.point_moved <= moved;
      out_q.any_moved   <= flag_base | moved;
      out_q.max_error   <= max_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hw/rtl/jacobi_stencil_point_update.sv
// Jacobi point update for a 3D seven-point stencil in signed Q15.32. A front
// stage takes one beat, sums the neighbor pairs and forms the exact solution
// from the clamped grid indices, then hands the point through a two-entry
// queue to the back end. The back end runs four products (three axes, then
// the diagonal reciprocal) on one 16x47 multiplier, a 16-bit digit per cycle;
// up to three more points wait in the front register and the queue meanwhile.
// Results sit in an output register and carry the running any-moved flag and
// maximum error, both cleared by a sweep-start beat.
module jacobi_stencil_point_update #(
  parameter int GRID_N = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  jsp_pkg::in_t            in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output jsp_pkg::out_t           out_data_o,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_idx_i,
  input  logic [jsp_pkg::CfgW-1:0] cfg_data_i
);
  import jsp_pkg::*;

  cfg_t     cfg_q;
  fifo_st_t fifo_st;
  logic     push, pop;
  q_t       push_data, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_hx_sq <= CfgW'(47'd4536559206400);
      cfg_q.inv_hy_sq <= CfgW'(47'd4536559206400);
      cfg_q.inv_hz_sq <= CfgW'(47'd4536559206400);
      cfg_q.inv_diag  <= CfgW'(47'd677599);
      cfg_q.step_x    <= CfgW'(47'd132152840);
      cfg_q.step_y    <= CfgW'(47'd132152840);
      cfg_q.step_z    <= CfgW'(47'd132152840);
      cfg_q.epsilon   <= CfgW'(47'd42950);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgInvHx: cfg_q.inv_hx_sq <= cfg_data_i;
        CfgInvHy: cfg_q.inv_hy_sq <= cfg_data_i;
        CfgInvHz: cfg_q.inv_hz_sq <= cfg_data_i;
        CfgInvDg: cfg_q.inv_diag  <= cfg_data_i;
        CfgStepX: cfg_q.step_x    <= cfg_data_i;
        CfgStepY: cfg_q.step_y    <= cfg_data_i;
        CfgStepZ: cfg_q.step_z    <= cfg_data_i;
        CfgEps:   cfg_q.epsilon   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  jsp_front #(
    .GRID_N (GRID_N)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .fifo_st_i   (fifo_st),
    .push_o      (push),
    .push_data_o (push_data)
  );

  jsp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .st_o        (fifo_st)
  );

  jsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .fifo_st_i   (fifo_st),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
